>>> hdl/gha_pkg.sv
package gha_pkg;

  localparam int BlkW    = 128;
  localparam int HalfW   = 64;
  localparam int CfgIdxW = 8;

  typedef logic [BlkW-1:0]    blk_t;
  typedef logic [HalfW-1:0]   half_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_HIGH = 8'd0,
    REG_KEY_LOW  = 8'd1
  } cfg_reg_t;

  // Contents of the input register, as seen by the multiply stage.
  typedef struct packed {
    logic valid;
    logic last;
    blk_t blk;
  } in_stage_t;

  // GCM numbers bits from the most significant end: bit 0 of a block is
  // the coefficient of x^0. Reversing gives an ordinary polynomial vector.
  function automatic blk_t bit_rev(input blk_t v);
    blk_t r;
    for (int i = 0; i < BlkW; i++) begin
      r[i] = v[BlkW-1-i];
    end
    return r;
  endfunction

  // Product in GF(2^128) modulo x^128 + x^7 + x^2 + x + 1, in GCM bit order.
  function automatic blk_t gf_mul(input blk_t x, input blk_t h);
    blk_t                a;
    blk_t                b;
    logic [2*BlkW-2:0]   c;
    logic [BlkW-2:0]     hi;
    logic [BlkW+6:0]     t;
    logic [6:0]          hi2;
    blk_t                r;
    a = bit_rev(x);
    b = bit_rev(h);
    // Carry-less product, one output coefficient at a time.
    for (int k = 0; k < 2*BlkW-1; k++) begin
      c[k] = 1'b0;
      for (int i = 0; i < BlkW; i++) begin
        if ((k - i >= 0) && (k - i < BlkW)) begin
          c[k] = c[k] ^ (a[i] & b[k-i]);
        end
      end
    end
    // Two folds of x^128 = x^7 + x^2 + x + 1 bring the result below x^128.
    hi = c[2*BlkW-2:BlkW];
    t = {7'd0, c[BlkW-1:0]}
      ^ {8'd0, hi}
      ^ {7'd0, hi, 1'b0}
      ^ {6'd0, hi, 2'b0}
      ^ {1'b0, hi, 7'b0};
    hi2 = t[BlkW+6:BlkW];
    r = t[BlkW-1:0]
      ^ {121'd0, hi2}
      ^ {120'd0, hi2, 1'b0}
      ^ {119'd0, hi2, 2'b0}
      ^ {114'd0, hi2, 7'b0};
    return bit_rev(r);
  endfunction

endpackage

>>> hdl/gha_ifs.sv
interface gha_in_if import gha_pkg::*;;
  logic  valid;
  logic  ready;
  half_t block_high;
  half_t block_low;
  logic  last_block;

  modport source (output valid, output block_high, output block_low, output last_block,
                  input ready);
  modport sink   (input valid, input block_high, input block_low, input last_block,
                  output ready);
endinterface

interface gha_out_if import gha_pkg::*;;
  logic  valid;
  logic  ready;
  half_t tag_high;
  half_t tag_low;

  modport source (output valid, output tag_high, output tag_low, input ready);
  modport sink   (input valid, input tag_high, input tag_low, output ready);
endinterface

interface gha_cfg_if import gha_pkg::*;;
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  half_t    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/gha_cfg_regs.sv
module gha_cfg_regs import gha_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  gha_cfg_if.sink      cfg,
  output blk_t         hash_key
);

  half_t key_high;
  half_t key_low;

  assign cfg.ready = 1'b1;
  assign hash_key  = {key_high, key_low};

  // Writes to indexes beyond the key halves are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (cfg.valid) begin
      if (cfg.index == REG_KEY_HIGH) begin
        key_high <= cfg.data;
      end
      if (cfg.index == REG_KEY_LOW) begin
        key_low <= cfg.data;
      end
    end
  end

endmodule

>>> hdl/gha_in_reg.sv
module gha_in_reg import gha_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  gha_in_if.sink    blk_in,
  input  logic      advance,
  output in_stage_t stage
);

  logic valid;
  logic last;
  blk_t blk;

  assign blk_in.ready = !valid || advance;
  assign stage        = '{valid: valid, last: last, blk: blk};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (blk_in.valid && blk_in.ready) begin
      valid <= 1'b1;
    end else if (advance) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (blk_in.valid && blk_in.ready) begin
      last <= blk_in.last_block;
      blk  <= {blk_in.block_high, blk_in.block_low};
    end
  end

endmodule

>>> hdl/gha_core.sv
module gha_core import gha_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  in_stage_t  stage,
  input  blk_t       hash_key,
  output logic       advance,
  gha_out_if.source  tag_out
);

  blk_t acc;
  blk_t prod;
  blk_t tag;
  logic tag_valid;

  assign prod = gf_mul(acc ^ stage.blk, hash_key);

  // Only a last item needs the result register; others always move on.
  assign advance = stage.valid && !(stage.last && tag_valid && !tag_out.ready);

  assign tag_out.valid    = tag_valid;
  assign tag_out.tag_high = tag[BlkW-1:HalfW];
  assign tag_out.tag_low  = tag[HalfW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      tag_valid <= 1'b0;
    end else begin
      if (advance) begin
        acc <= stage.last ? '0 : prod;
      end
      if (advance && stage.last) begin
        tag_valid <= 1'b1;
      end else if (tag_out.ready) begin
        tag_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage.last) begin
      tag <= prod;
    end
  end

endmodule

>>> hdl/ghash_gf128_accumulator.sv
// GCM GHASH engine: each 128-bit block item is XORed into the running
// accumulator and multiplied by the hash subkey H in GF(2^128), and an item
// marked last returns the tag and clears the accumulator. An item enters an
// input register and is folded into the accumulator from there by a
// combinational multiply-reduce, so one item is accepted per clock; a waiting
// tag holds back only the next last item. The user must write H as two 64-bit
// halves through the configuration channel (index 0 upper, index 1 lower)
// only while no item is in flight, which the block does not enforce; other
// indexes are ignored.
module ghash_gf128_accumulator import gha_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  gha_cfg_if.sink   cfg,
  gha_in_if.sink    blk_in,
  gha_out_if.source tag_out
);

  blk_t      hash_key;
  in_stage_t stage;
  logic      advance;

  gha_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .hash_key (hash_key)
  );

  gha_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .blk_in  (blk_in),
    .advance (advance),
    .stage   (stage)
  );

  gha_core u_core (
    .clk      (clk),
    .rst      (rst),
    .stage    (stage),
    .hash_key (hash_key),
    .advance  (advance),
    .tag_out  (tag_out)
  );

endmodule
